@@ hdl/dhcpopt_pkg.sv @@
`timescale 1ns / 1ps

package dhcpopt_pkg;

    // size of the options area that is parsed
    localparam int OPTIONS_BYTES = 312;
    localparam int POS_W         = $clog2(OPTIONS_BYTES + 1);
    localparam int COOKIE_BYTES  = 4;

    // reply stream
    localparam int REPLY_LEN   = 38;
    localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

    // request queue between parser and reply generator
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SECONDS  = 2'd2;

    localparam logic [31:0] SERVER_ADDRESS_RST = 32'hC0A8_0101;
    localparam logic [31:0] SUBNET_MASK_RST    = 32'hFFFF_FF00;
    localparam logic [31:0] LEASE_SECONDS_RST  = 32'd3600;

    // option tags
    localparam logic [7:0] TAG_PAD       = 8'd0;
    localparam logic [7:0] TAG_SUBNET    = 8'd1;
    localparam logic [7:0] TAG_ROUTER    = 8'd3;
    localparam logic [7:0] TAG_DNS       = 8'd6;
    localparam logic [7:0] TAG_LEASE     = 8'd51;
    localparam logic [7:0] TAG_MSG_TYPE  = 8'd53;
    localparam logic [7:0] TAG_SERVER_ID = 8'd54;
    localparam logic [7:0] TAG_END       = 8'd255;

    // message types
    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_OFFER    = 8'd2;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;
    localparam logic [7:0] MSG_ACK      = 8'd5;

    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
    localparam logic [7:0]  LEN_ONE      = 8'd1;
    localparam logic [7:0]  LEN_WORD     = 8'd4;

    typedef enum logic [2:0] {
        PH_COOKIE,
        PH_TAG,
        PH_LEN,
        PH_LEN53,
        PH_SKIP,
        PH_VAL53,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
    } out_item_t;

    // reply request from parser to generator
    typedef struct packed {
        logic push;
        logic is_ack;
    } reply_req_t;

    function automatic logic [7:0] reply_byte_at(
        input logic [REPLY_IDX_W-1:0] idx,
        input logic                   is_ack,
        input logic [31:0]            srv,
        input logic [31:0]            mask,
        input logic [31:0]            lease
    );
        logic [7:0] b;
        logic [7:0] mt;
        mt = is_ack ? MSG_ACK : MSG_OFFER;
        case (idx)
            6'd0:    b = MAGIC_COOKIE[31:24];
            6'd1:    b = MAGIC_COOKIE[23:16];
            6'd2:    b = MAGIC_COOKIE[15:8];
            6'd3:    b = MAGIC_COOKIE[7:0];
            6'd4:    b = TAG_MSG_TYPE;
            6'd5:    b = LEN_ONE;
            6'd6:    b = mt;
            6'd7:    b = TAG_SERVER_ID;
            6'd8:    b = LEN_WORD;
            6'd9:    b = srv[31:24];
            6'd10:   b = srv[23:16];
            6'd11:   b = srv[15:8];
            6'd12:   b = srv[7:0];
            6'd13:   b = TAG_SUBNET;
            6'd14:   b = LEN_WORD;
            6'd15:   b = mask[31:24];
            6'd16:   b = mask[23:16];
            6'd17:   b = mask[15:8];
            6'd18:   b = mask[7:0];
            6'd19:   b = TAG_ROUTER;
            6'd20:   b = LEN_WORD;
            6'd21:   b = srv[31:24];
            6'd22:   b = srv[23:16];
            6'd23:   b = srv[15:8];
            6'd24:   b = srv[7:0];
            6'd25:   b = TAG_DNS;
            6'd26:   b = LEN_WORD;
            6'd27:   b = srv[31:24];
            6'd28:   b = srv[23:16];
            6'd29:   b = srv[15:8];
            6'd30:   b = srv[7:0];
            6'd31:   b = TAG_LEASE;
            6'd32:   b = LEN_WORD;
            6'd33:   b = lease[31:24];
            6'd34:   b = lease[23:16];
            6'd35:   b = lease[15:8];
            6'd36:   b = lease[7:0];
            default: b = TAG_END;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/dhcpopt_parser.sv @@
`timescale 1ns / 1ps

module dhcpopt_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dhcpopt_pkg::in_item_t item,
    output dhcpopt_pkg::reply_req_t req
);
    import dhcpopt_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       skip_reg, skip_next;
    logic [7:0]       type_reg, type_next;
    logic             seen_reg, seen_next;
    logic [7:0]       skip_dec;

    assign skip_dec = skip_reg - 8'd1;

    // next state of the option walk, before the end-of-packet clear
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        type_next  = type_reg;
        seen_next  = seen_reg;
        if (pos_reg < POS_W'(OPTIONS_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_COOKIE:
                begin
                    if (pos_reg >= POS_W'(COOKIE_BYTES - 1))
                        phase_next = PH_TAG;
                end
                PH_TAG:
                begin
                    if (item.opt_byte == TAG_END)
                        phase_next = PH_DONE;
                    else if (item.opt_byte == TAG_MSG_TYPE)
                        phase_next = PH_LEN53;
                    else if (item.opt_byte != TAG_PAD)
                        phase_next = PH_LEN;
                end
                PH_LEN, PH_LEN53:
                begin
                    if (item.opt_byte == 8'd0)
                        phase_next = PH_TAG;
                    else
                    begin
                        skip_next  = item.opt_byte;
                        phase_next = (phase_reg == PH_LEN53) ? PH_VAL53 : PH_SKIP;
                    end
                end
                PH_VAL53, PH_SKIP:
                begin
                    if (phase_reg == PH_VAL53 && !seen_reg)
                    begin
                        type_next = item.opt_byte;
                        seen_next = 1'b1;
                    end
                    skip_next  = skip_dec;
                    phase_next = (skip_dec == 8'd0) ? PH_TAG : PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // reply decision on the final byte of a packet
    always_comb
    begin
        req.push   = 1'b0;
        req.is_ack = 1'b0;
        if (accept && item.last && seen_next)
        begin
            if (type_next == MSG_DISCOVER)
                req.push = 1'b1;
            else if (type_next == MSG_REQUEST)
            begin
                req.push   = 1'b1;
                req.is_ack = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COOKIE;
            pos_reg   <= '0;
            skip_reg  <= '0;
            type_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last)
            begin
                phase_reg <= PH_COOKIE;
                pos_reg   <= '0;
                skip_reg  <= '0;
                type_reg  <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                skip_reg  <= skip_next;
                type_reg  <= type_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

@@ hdl/dhcpopt_queue.sv @@
`timescale 1ns / 1ps

module dhcpopt_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dhcpopt_pkg::reply_req_t push_req,
    input  logic                    pop,
    output logic                    pop_is_ack,
    output logic                    not_empty,
    output logic                    full
);
    import dhcpopt_pkg::*;

    logic [QUEUE_DEPTH-1:0] entry_reg;
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_W-1:0]      count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign pop_is_ack = entry_reg[rd_ptr_reg];
    assign do_push    = push_req.push && !full;
    assign do_pop     = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_req.is_ack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

@@ hdl/dhcpopt_reply.sv @@
`timescale 1ns / 1ps

module dhcpopt_reply (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dhcpopt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_wr_data,
    input  logic                             req_avail,
    input  logic                             req_is_ack,
    output logic                             req_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output dhcpopt_pkg::out_item_t           out_data
);
    import dhcpopt_pkg::*;

    logic [31:0]            server_address_reg;
    logic [31:0]            subnet_mask_reg;
    logic [31:0]            lease_seconds_reg;
    logic                   active_reg;
    logic                   is_ack_reg;
    logic [REPLY_IDX_W-1:0] idx_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;
    logic                   advance;
    logic                   at_end;

    assign advance   = active_reg && (!out_valid_reg || !out_stall);
    assign at_end    = (idx_reg == REPLY_IDX_W'(REPLY_LEN - 1));
    assign req_pop   = req_avail && (!active_reg || (advance && at_end));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_address_reg <= SERVER_ADDRESS_RST;
            subnet_mask_reg    <= SUBNET_MASK_RST;
            lease_seconds_reg  <= LEASE_SECONDS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SERVER_ADDRESS: server_address_reg <= cfg_wr_data;
                CFG_SUBNET_MASK:    subnet_mask_reg    <= cfg_wr_data;
                CFG_LEASE_SECONDS:  lease_seconds_reg  <= cfg_wr_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (advance)
            begin
                if (at_end)
                    active_reg <= 1'b0;
                idx_reg <= idx_reg + REPLY_IDX_W'(1);
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
            is_ack_reg <= req_is_ack;
        if (advance)
        begin
            out_reg.reply_byte <= reply_byte_at(idx_reg, is_ack_reg, server_address_reg,
                                                subnet_mask_reg, lease_seconds_reg);
            out_reg.reply_last <= at_end;
        end
    end

endmodule

@@ hdl/dhcp_option_parse_and_reply.sv @@
`timescale 1ns / 1ps

// channel  | valid      | stall       | payload
// ---------+------------+-------------+---------------------------------
// in       | in_valid   | in_stall    | in_data  : opt_byte, last
// out      | out_valid  | out_stall   | out_data : reply_byte, reply_last
// cfg      | cfg_wr_en  | (none)      | cfg_index, cfg_wr_data
//
// the parser takes one options byte per cycle unless the reply queue is full, and never waits on out_stall directly
// a discover or request ends in a queued reply request; the generator sends its
// 38 bytes one per cycle while out_stall is low, each through the output register
// in_stall rises only when the four-entry reply queue is full
// reset (rst_n low, asynchronous) returns the parser to the cookie phase,
// empties the queue and restores the configuration defaults

module dhcp_option_parse_and_reply (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dhcpopt_pkg::in_item_t             in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dhcpopt_pkg::out_item_t            out_data,
    input  logic                              cfg_wr_en,
    input  logic [dhcpopt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_wr_data
);
    import dhcpopt_pkg::*;

    logic       in_accept;
    reply_req_t parse_req;
    logic       q_full;
    logic       q_not_empty;
    logic       q_is_ack;
    logic       q_pop;

    // input side waits only on a full reply queue
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    // front: option walk and message type decision
    dhcpopt_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .req    (parse_req)
    );

    // short queue of pending replies (offer or ack)
    dhcpopt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_req   (parse_req),
        .pop        (q_pop),
        .pop_is_ack (q_is_ack),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    // back: reply stream generator with output register and config registers
    dhcpopt_reply u_reply (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .req_avail   (q_not_empty),
        .req_is_ack  (q_is_ack),
        .req_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

@@ hdl/dhcpopt_checker.sv @@
`timescale 1ns / 1ps

module dhcpopt_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input dhcpopt_pkg::in_item_t  in_data,
    input logic                   out_valid,
    input logic                   out_stall,
    input dhcpopt_pkg::out_item_t out_data
);
    import dhcpopt_pkg::*;

    // stalled request byte holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("request byte changed under stall");

    // stalled reply byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("reply byte changed under stall");

    // the final reply byte is always the end tag
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reply_last |-> out_data.reply_byte == TAG_END)
        else $error("reply_last on a byte other than the end tag");

    // a final reply byte is never directly followed by another final byte
    a_no_double_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.reply_last
        |=> !(out_valid && out_data.reply_last))
        else $error("two final reply bytes in a row");

    // no reply bytes during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("reply valid during reset");

endmodule

bind dhcp_option_parse_and_reply dhcpopt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/sv/tb_dhcp_option_parse_and_reply.sv @@
`timescale 1ns / 1ps

module tb_dhcp_option_parse_and_reply;
    import dhcpopt_pkg::*;

    // 8 ns clock, long enough watchdog for heavy output back-pressure
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef bit [7:0] byte_q_t[$];

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wr_data;

    // idle rates in percent of cycles, changed per test
    int send_idle_pct = 25;
    int recv_idle_pct = 75;

    // long output hold-off request, picked up by the receiver process
    int hold_req  = 0;
    int hold_left = 0;

    int bytes_sent = 0;
    int errors     = 0;

    // reply bytes still owed by the block, oldest first
    out_item_t reply_bytes_due[$];

    // shadow of the configuration registers
    logic [31:0] shadow_server;
    logic [31:0] shadow_mask;
    logic [31:0] shadow_lease;

    // shadow of the options walk
    int          walk_pos;
    phase_t      walk_phase;
    logic [7:0]  walk_skip;
    logic [7:0]  msg_type;
    logic        msg_type_seen;

    dhcp_option_parse_and_reply u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_dhcp_option_parse_and_reply failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // start of a new packet
    task automatic restart_walk();
        walk_pos      = 0;
        walk_phase    = PH_COOKIE;
        walk_skip     = 8'd0;
        msg_type      = 8'd0;
        msg_type_seen = 1'b0;
    endtask

    // queue the 38 reply bytes built from the current register values
    task automatic queue_reply(input logic [7:0] reply_type);
        logic [8*REPLY_LEN-1:0] stream;
        out_item_t              item;
        stream = {MAGIC_COOKIE,
                  TAG_MSG_TYPE,  LEN_ONE,  reply_type,
                  TAG_SERVER_ID, LEN_WORD, shadow_server,
                  TAG_SUBNET,    LEN_WORD, shadow_mask,
                  TAG_ROUTER,    LEN_WORD, shadow_server,
                  TAG_DNS,       LEN_WORD, shadow_server,
                  TAG_LEASE,     LEN_WORD, shadow_lease,
                  TAG_END};
        for (int k = 0; k < REPLY_LEN; k++)
        begin
            item.reply_byte = stream[8*(REPLY_LEN-1-k) +: 8];
            item.reply_last = (k == REPLY_LEN - 1);
            reply_bytes_due.push_back(item);
        end
    endtask

    // advance the options walk by one accepted request byte
    task automatic parse_options_byte(input in_item_t req);
        logic [7:0] b;
        b = req.opt_byte;
        // bytes beyond the options area are not parsed at all
        if (walk_pos < OPTIONS_BYTES)
        begin
            case (walk_phase)
                PH_COOKIE:
                    if (walk_pos >= COOKIE_BYTES - 1)
                        walk_phase = PH_TAG;
                PH_TAG:
                    if (b == TAG_END)
                        walk_phase = PH_DONE;
                    else if (b == TAG_MSG_TYPE)
                        walk_phase = PH_LEN53;
                    else if (b != TAG_PAD)
                        walk_phase = PH_LEN;
                PH_LEN, PH_LEN53:
                    // a zero length means the next byte is a tag again
                    if (b == 8'd0)
                        walk_phase = PH_TAG;
                    else
                    begin
                        walk_skip  = b;
                        walk_phase = (walk_phase == PH_LEN53) ? PH_VAL53 : PH_SKIP;
                    end
                PH_VAL53, PH_SKIP:
                begin
                    // only the first recorded message type counts
                    if (walk_phase == PH_VAL53 && !msg_type_seen)
                    begin
                        msg_type      = b;
                        msg_type_seen = 1'b1;
                    end
                    walk_skip  = walk_skip - 8'd1;
                    walk_phase = (walk_skip == 8'd0) ? PH_TAG : PH_SKIP;
                end
                default:
                    walk_phase = PH_DONE;
            endcase
            walk_pos++;
        end
        // the last flag decides the packet even past the area
        if (req.last)
        begin
            if (msg_type_seen && msg_type == MSG_DISCOVER)
                queue_reply(MSG_OFFER);
            else if (msg_type_seen && msg_type == MSG_REQUEST)
                queue_reply(MSG_ACK);
            restart_walk();
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random or long stall, and the reply check
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : reply_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_bytes_due.size() == 0)
            begin
                $error("unexpected reply byte 0x%02h reply_last %0b",
                       out_data.reply_byte, out_data.reply_last);
                errors++;
            end
            else
            begin
                want = reply_bytes_due.pop_front();
                if (out_data.reply_byte !== want.reply_byte)
                begin
                    $error("reply_byte expected 0x%02h actual 0x%02h",
                           want.reply_byte, out_data.reply_byte);
                    errors++;
                end
                if (out_data.reply_last !== want.reply_last)
                begin
                    $error("reply_last expected %0b actual %0b",
                           want.reply_last, out_data.reply_last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------

    // offer one request byte, predict once it is taken
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int       gap;
        in_item_t req;
        req.opt_byte = b;
        req.last     = is_last;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        parse_options_byte(req);
    endtask

    task automatic send_packet(input byte_q_t pkt);
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // drop valid and let every owed reply byte drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reply_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers, only while nothing is in flight
    task automatic set_config(input logic [31:0] server, input logic [31:0] mask,
                              input logic [31:0] lease);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [31:0]          val [3];
        idx[0] = CFG_SERVER_ADDRESS;
        idx[1] = CFG_SUBNET_MASK;
        idx[2] = CFG_LEASE_SECONDS;
        val[0] = server;
        val[1] = mask;
        val[2] = lease;
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= val[i];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        shadow_server = server;
        shadow_mask   = mask;
        shadow_lease  = lease;
    endtask

    // shortest packet that can earn a reply
    function automatic byte_q_t short_packet(input logic [7:0] mtype);
        return {MAGIC_COOKIE[31:24], MAGIC_COOKIE[23:16], MAGIC_COOKIE[15:8],
                MAGIC_COOKIE[7:0], TAG_MSG_TYPE, LEN_ONE, mtype};
    endfunction

    // any tag that is neither pad, end nor message type
    function automatic logic [7:0] plain_tag();
        logic [7:0] t;
        do
            t = 8'($urandom_range(1, 254));
        while (t == TAG_MSG_TYPE);
        return t;
    endfunction

    // mostly well-formed options with random content, some noise
    task automatic send_random_packet();
        byte_q_t    pkt;
        int         nopt;
        int         len;
        int         r;
        bit         cut;
        logic [7:0] mtype;
        pkt = {};
        cut = 1'b0;
        if ($urandom_range(99) < 10)
        begin
            // noise: raw bytes, sometimes ending inside the cookie
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
            nopt = $urandom_range(1, 5);
            for (int n = 0; n < nopt && !cut; n++)
            begin
                r = $urandom_range(99);
                if (r < 15)
                    pkt.push_back(TAG_PAD);
                else if (r < 50)
                begin
                    pkt.push_back(plain_tag());
                    if ($urandom_range(19) == 0)
                    begin
                        // long option that the packet ends inside of
                        len = $urandom_range(9, 255);
                        pkt.push_back(8'(len));
                        repeat ($urandom_range(0, 8))
                            pkt.push_back(8'($urandom_range(0, 255)));
                        cut = 1'b1;
                    end
                    else
                    begin
                        len = $urandom_range(0, 4);
                        pkt.push_back(8'(len));
                        repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    // message type, mostly discover or request
                    if ($urandom_range(99) < 75)
                        mtype = $urandom_range(1) ? MSG_REQUEST : MSG_DISCOVER;
                    else
                        mtype = 8'($urandom_range(0, 255));
                    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
                    pkt.push_back(TAG_MSG_TYPE);
                    pkt.push_back(8'(len));
                    if (len > 0)
                    begin
                        pkt.push_back(mtype);
                        repeat (len - 1) pkt.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            // end tag with trailing junk, or no end tag at all
            if (!cut && $urandom_range(99) < 60)
            begin
                pkt.push_back(TAG_END);
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_packet(pkt);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of the cookie, pad, zero-length options, repeated type, end tag
    task automatic test_directed();
        byte_q_t pkt;
        pkt = {8'hFF, 8'h00, 8'hFF, 8'h00, TAG_MSG_TYPE, LEN_ONE, MSG_DISCOVER};
        send_packet(pkt);
        // zero-length type records nothing, the first real type wins,
        // bytes after the end tag are ignored -> ack
        pkt = {MAGIC_COOKIE[31:24], MAGIC_COOKIE[23:16], MAGIC_COOKIE[15:8],
               MAGIC_COOKIE[7:0], TAG_PAD, TAG_MSG_TYPE, 8'd0, 8'd12, 8'd0,
               TAG_MSG_TYPE, LEN_ONE, MSG_REQUEST, TAG_MSG_TYPE, LEN_ONE,
               MSG_DISCOVER, TAG_END, TAG_MSG_TYPE};
        send_packet(pkt);
    endtask

    // all-zero and all-one register values
    task automatic test_config_extremes();
        set_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_packet(short_packet(MSG_DISCOVER));
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(short_packet(MSG_REQUEST));
    endtask

    task automatic test_random_traffic(input int n_bytes, input int snd_pct,
                                       input int rcv_pct);
        int first;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes)
            send_random_packet();
    endtask

    // output held off long enough for the reply queue to fill and stall input
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_req      = HOLD_CYCLES;
        repeat (8)
            send_packet(short_packet($urandom_range(1) ? MSG_REQUEST : MSG_DISCOVER));
        // sender waits for every reply before going on
        wait_idle();
    endtask

    // a type option whose value byte lies just past the options area
    task automatic test_area_overflow();
        byte_q_t pkt;
        int      room;
        int      len;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pkt = {};
        repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
        while (pkt.size() < OPTIONS_BYTES - 2)
        begin
            room = OPTIONS_BYTES - 2 - pkt.size();
            if (room >= 2 && $urandom_range(3) == 0)
            begin
                len = $urandom_range(0, (room - 2 < 6) ? room - 2 : 6);
                pkt.push_back(plain_tag());
                pkt.push_back(8'(len));
                repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
            end
            else
                pkt.push_back(TAG_PAD);
        end
        // tag and length land in the area, the discover value does not
        pkt.push_back(TAG_MSG_TYPE);
        pkt.push_back(LEN_ONE);
        pkt.push_back(MSG_DISCOVER);
        repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
        send_packet(pkt);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_SERVER_ADDRESS;
        cfg_wr_data = 32'd0;
        shadow_server = SERVER_ADDRESS_RST;
        shadow_mask   = SUBNET_MASK_RST;
        shadow_lease  = LEASE_SECONDS_RST;
        restart_walk();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_extremes();

        set_config($urandom, $urandom, $urandom);
        test_random_traffic(15, 25, 75);
        test_backpressure();

        set_config($urandom, $urandom, $urandom);
        test_random_traffic(15, 75, 25);

        set_config(32'hFFFF_FFFF, 32'h0000_0000, $urandom);
        test_random_traffic(15, 0, 0);

        set_config($urandom, $urandom, $urandom);
        test_area_overflow();

        // drain, then give a stray reply time to show up
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (reply_bytes_due.size() != 0)
        begin
            $error("%0d reply bytes never arrived", reply_bytes_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_dhcp_option_parse_and_reply passed");
        else
            $display("tb_dhcp_option_parse_and_reply failed");
        $finish;
    end

endmodule
